### rtl/core/lprd_pkg.sv
// Package for the lidar point range gate and decimation filter.
// Holds the field widths, the register index codes and the configuration bundle.
// No dependencies.
package lprd_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DECIM_WIDTH = 8;
  localparam int RANGE_WIDTH = 23;
  localparam int INTEN_WIDTH = 16;
  localparam int TIME_WIDTH  = 63;
  localparam int REL_WIDTH   = 32;
  localparam int DIFF_WIDTH  = TIME_WIDTH + 1;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = RANGE_WIDTH;

  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;
  localparam int BOUND_WIDTH = 2 * RANGE_WIDTH;
  localparam int CMP_WIDTH   = (SUM_WIDTH > BOUND_WIDTH) ? SUM_WIDTH : BOUND_WIDTH;

  localparam logic [DECIM_WIDTH-1:0] DECIM_RESET     = DECIM_WIDTH'(1);
  localparam logic [RANGE_WIDTH-1:0] MIN_RANGE_RESET = '0;
  localparam logic [RANGE_WIDTH-1:0] MAX_RANGE_RESET = '1;
  localparam logic [BOUND_WIDTH-1:0] HI_BOUND_RESET  =
    BOUND_WIDTH'(MAX_RANGE_RESET) * BOUND_WIDTH'(MAX_RANGE_RESET);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DECIM     = 2'd0,
    REG_MIN_RANGE = 2'd1,
    REG_MAX_RANGE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DECIM_WIDTH-1:0] decimation_factor;
    logic [BOUND_WIDTH-1:0] lo_bound;
    logic [BOUND_WIDTH-1:0] hi_bound;
  } cfg_t;

endpackage

### rtl/core/lprd_cfg.sv
// Configuration registers of the range gate filter, with the squared range bounds.
// Depends on lprd_pkg.
module lprd_cfg
  import lprd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  logic [DECIM_WIDTH-1:0] decimation_factor;
  logic [RANGE_WIDTH-1:0] min_range_mm;
  logic [RANGE_WIDTH-1:0] max_range_mm;
  logic [BOUND_WIDTH-1:0] lo_bound;
  logic [BOUND_WIDTH-1:0] hi_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor <= DECIM_RESET;
      min_range_mm      <= MIN_RANGE_RESET;
      max_range_mm      <= MAX_RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DECIM:     decimation_factor <= cfg_data[DECIM_WIDTH-1:0];
        REG_MIN_RANGE: min_range_mm      <= cfg_data[RANGE_WIDTH-1:0];
        REG_MAX_RANGE: max_range_mm      <= cfg_data[RANGE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The bounds are registered from the range registers and follow them in the next cycle,
  // which is well inside the time an item needs to reach the range compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo_bound <= '0;
      hi_bound <= HI_BOUND_RESET;
    end else begin
      lo_bound <= BOUND_WIDTH'(min_range_mm) * BOUND_WIDTH'(min_range_mm);
      hi_bound <= BOUND_WIDTH'(max_range_mm) * BOUND_WIDTH'(max_range_mm);
    end
  end

  assign cfg.decimation_factor = decimation_factor;
  assign cfg.lo_bound          = lo_bound;
  assign cfg.hi_bound          = hi_bound;

endmodule

### rtl/core/lprd_decim.sv
// Decimation counter: decides whether the offered point falls on the kept slot.
// Depends on lprd_pkg.
module lprd_decim
  import lprd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   first_of_scan,
  input  logic [DECIM_WIDTH-1:0] decimation_factor,
  output logic                   passes
);

  logic [DECIM_WIDTH-1:0] decim_count;
  logic [DECIM_WIDTH-1:0] decim_count_next;
  logic [DECIM_WIDTH-1:0] factor;
  logic [DECIM_WIDTH-1:0] count_now;
  logic [DECIM_WIDTH:0]   count_inc;

  always_comb begin
    // A factor of zero behaves as one.
    factor    = (decimation_factor == '0) ? DECIM_WIDTH'(1) : decimation_factor;
    count_now = first_of_scan ? '0 : decim_count;
    passes    = (count_now == '0);
    count_inc = {1'b0, count_now} + (DECIM_WIDTH + 1)'(1);
    if (count_inc >= {1'b0, factor}) begin
      decim_count_next = '0;
    end else begin
      decim_count_next = count_inc[DECIM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decim_count <= '0;
    end else if (accept) begin
      decim_count <= decim_count_next;
    end
  end

endmodule

### rtl/core/lprd_pipe.sv
// Three-stage datapath: input register, squares and relative time, range gate
// and output register. Depends on lprd_pkg.
module lprd_pipe
  import lprd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          load,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_in,
  input  logic signed [COORD_WIDTH-1:0] y_in,
  input  logic signed [COORD_WIDTH-1:0] z_in,
  input  logic [INTEN_WIDTH-1:0]        inten_in,
  input  logic [TIME_WIDTH-1:0]         point_time_in,
  input  logic [TIME_WIDTH-1:0]         scan_start_in,
  input  cfg_t                          cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic signed [COORD_WIDTH-1:0] z_out,
  output logic [INTEN_WIDTH-1:0]        intensity_out,
  output logic signed [REL_WIDTH-1:0]   rel_time_ns
);

  // Stage 1: captured point.
  logic                          s1_valid;
  logic signed [COORD_WIDTH-1:0] s1_x, s1_y, s1_z;
  logic [INTEN_WIDTH-1:0]        s1_inten;
  logic [TIME_WIDTH-1:0]         s1_pt, s1_st;

  // Stage 2: squares and saturated relative time.
  logic                          s2_valid;
  logic signed [COORD_WIDTH-1:0] s2_x, s2_y, s2_z;
  logic [INTEN_WIDTH-1:0]        s2_inten;
  logic [SQ_WIDTH-1:0]           s2_sqx, s2_sqy, s2_sqz;
  logic signed [REL_WIDTH-1:0]   s2_rel;

  logic s3_free, s2_free, s1_free;

  logic signed [SQ_WIDTH-1:0]   sqx, sqy, sqz;
  logic [DIFF_WIDTH-1:0]        diff;
  logic signed [REL_WIDTH-1:0]  rel_sat;
  logic [CMP_WIDTH-1:0]         range_sq;
  logic                         in_range;

  assign s3_free  = !out_valid || out_ready;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  always_comb begin
    sqx  = SQ_WIDTH'(s1_x) * SQ_WIDTH'(s1_x);
    sqy  = SQ_WIDTH'(s1_y) * SQ_WIDTH'(s1_y);
    sqz  = SQ_WIDTH'(s1_z) * SQ_WIDTH'(s1_z);
    diff = {1'b0, s1_pt} - {1'b0, s1_st};
    // Clamp the 64-bit difference to the signed 32-bit range.
    if (!diff[DIFF_WIDTH-1] && (diff[DIFF_WIDTH-2:REL_WIDTH-1] != '0)) begin
      rel_sat = {1'b0, {(REL_WIDTH-1){1'b1}}};
    end else if (diff[DIFF_WIDTH-1] && (diff[DIFF_WIDTH-2:REL_WIDTH-1] != '1)) begin
      rel_sat = {1'b1, {(REL_WIDTH-1){1'b0}}};
    end else begin
      rel_sat = diff[REL_WIDTH-1:0];
    end
  end

  // The sum is kept at full width; a 64-bit saturation would not change the
  // outcome of the compare because both bounds lie far below it.
  always_comb begin
    range_sq = CMP_WIDTH'(s2_sqx) + CMP_WIDTH'(s2_sqy) + CMP_WIDTH'(s2_sqz);
    in_range = (range_sq >= CMP_WIDTH'(cfg.lo_bound)) &&
               (range_sq <= CMP_WIDTH'(cfg.hi_bound));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= load;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        out_valid <= s2_valid && in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= x_in;
      s1_y     <= y_in;
      s1_z     <= z_in;
      s1_inten <= inten_in;
      s1_pt    <= point_time_in;
      s1_st    <= scan_start_in;
    end
    if (s2_free && s1_valid) begin
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_z     <= s1_z;
      s2_inten <= s1_inten;
      s2_sqx   <= sqx;
      s2_sqy   <= sqy;
      s2_sqz   <= sqz;
      s2_rel   <= rel_sat;
    end
    if (s3_free && s2_valid) begin
      x_out         <= s2_x;
      y_out         <= s2_y;
      z_out         <= s2_z;
      intensity_out <= s2_inten;
      rel_time_ns   <= s2_rel;
    end
  end

endmodule

### rtl/core/lidar_point_range_decimate_filter_top.sv
// Top level of the lidar point range gate and decimation filter.
// Depends on lprd_pkg, lprd_cfg, lprd_decim and lprd_pipe.

// The filter accepts one point per clock cycle while the output is not stalled. A
// kept point passes the input register, the register after the squaring multipliers
// and the output register after the range compare before it appears on the output.
// Points skipped by decimation, non-finite points and points outside the range gate
// are dropped without producing any output. A stalled output holds the pipeline,
// which keeps accepting until all three stages are full. Range writes take effect
// on the next accepted point; write configuration only while no points are in
// flight.
module lidar_point_range_decimate_filter_top
  import lprd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          first_of_scan,
  input  logic                          point_finite,
  input  logic signed [COORD_WIDTH-1:0] x_mm,
  input  logic signed [COORD_WIDTH-1:0] y_mm,
  input  logic signed [COORD_WIDTH-1:0] z_mm,
  input  logic [INTEN_WIDTH-1:0]        intensity_in,
  input  logic [TIME_WIDTH-1:0]         point_time_ns,
  input  logic [TIME_WIDTH-1:0]         scan_start_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] x_out,
  output logic signed [COORD_WIDTH-1:0] y_out,
  output logic signed [COORD_WIDTH-1:0] z_out,
  output logic [INTEN_WIDTH-1:0]        intensity_out,
  output logic signed [REL_WIDTH-1:0]   rel_time_ns
);

  cfg_t cfg;
  logic accept;
  logic passes;
  logic load;

  assign accept = in_valid && in_ready;
  assign load   = accept && passes && point_finite;

  lprd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lprd_decim u_decim (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .first_of_scan     (first_of_scan),
    .decimation_factor (cfg.decimation_factor),
    .passes            (passes)
  );

  lprd_pipe u_pipe (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .load          (load),
    .in_ready      (in_ready),
    .x_in          (x_mm),
    .y_in          (y_mm),
    .z_in          (z_mm),
    .inten_in      (intensity_in),
    .point_time_in (point_time_ns),
    .scan_start_in (scan_start_ns),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .x_out         (x_out),
    .y_out         (y_out),
    .z_out         (z_out),
    .intensity_out (intensity_out),
    .rel_time_ns   (rel_time_ns)
  );

endmodule

### sim/testbench.sv
// Self-checking testbench for lidar_point_range_decimate_filter_top.
// A scoreboard class predicts decimation, range gating and relative time for
// every accepted point. Depends on lprd_pkg and the filter RTL.
module testbench;
  import lprd_pkg::*;

  localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_WIDTH - 1));
  localparam int RANGE_MAX = 2 ** RANGE_WIDTH - 1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = CFG_INDEX_WIDTH'(3);
  localparam int PHASES = 9;
  localparam int PHASE_POINTS = 72;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 2000;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    logic first;
    logic finite;
    logic signed [COORD_WIDTH-1:0] x, y, z;
    logic [INTEN_WIDTH-1:0] inten;
    logic [TIME_WIDTH-1:0] pt, st;
  } lidar_point_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x, y, z;
    logic [INTEN_WIDTH-1:0] inten;
    logic signed [REL_WIDTH-1:0] rel;
  } kept_point_t;

  class range_gate_scoreboard;
    logic [DECIM_WIDTH-1:0] factor;
    logic [RANGE_WIDTH-1:0] min_mm, max_mm;
    logic [DECIM_WIDTH-1:0] decim_pos;
    kept_point_t kept_q[$];
    int errors, predicted, checked;

    function new();
      factor = DECIM_RESET;
      min_mm = MIN_RANGE_RESET;
      max_mm = MAX_RANGE_RESET;
      decim_pos = '0;
      errors = 0;
      predicted = 0;
      checked = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_DECIM:     factor = data[DECIM_WIDTH-1:0];
        REG_MIN_RANGE: min_mm = data[RANGE_WIDTH-1:0];
        REG_MAX_RANGE: max_mm = data[RANGE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned square_mm(logic signed [COORD_WIDTH-1:0] v);
      longint w;
      w = v;
      return w * w;
    endfunction

    function void note_point(lidar_point_t p);
      logic [DECIM_WIDTH:0] step;
      logic [DECIM_WIDTH-1:0] group;
      logic passes;
      longint unsigned range_sq, lo, hi;
      longint rel;
      kept_point_t k;
      // A zero factor behaves like one: every point passes decimation.
      group = (factor == 0) ? DECIM_WIDTH'(1) : factor;
      if (p.first) decim_pos = '0;
      passes = (decim_pos == 0);
      step = decim_pos + 1'b1;
      decim_pos = (step >= group) ? '0 : step[DECIM_WIDTH-1:0];
      if (!passes || !p.finite) return;
      range_sq = square_mm(p.x) + square_mm(p.y) + square_mm(p.z);
      lo = 64'(min_mm) * 64'(min_mm);
      hi = 64'(max_mm) * 64'(max_mm);
      if (range_sq < lo || range_sq > hi) return;
      rel = $signed({1'b0, p.pt}) - $signed({1'b0, p.st});
      if (rel > 64'sd2147483647) rel = 64'sd2147483647;
      else if (rel < -64'sd2147483648) rel = -64'sd2147483648;
      k.x = p.x;
      k.y = p.y;
      k.z = p.z;
      k.inten = p.inten;
      k.rel = rel[REL_WIDTH-1:0];
      kept_q.insert(kept_q.size(), k);
      predicted++;
    endfunction

    task check_point(kept_point_t got);
      kept_point_t want;
      if (kept_q.size() == 0) begin
        report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                  got.x, got.y, got.z));
        return;
      end
      want = kept_q.pop_front();
      checked++;
      if (got.x !== want.x)
        report_mismatch($sformatf("x_out got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("y_out got %0d want %0d", got.y, want.y));
      if (got.z !== want.z)
        report_mismatch($sformatf("z_out got %0d want %0d", got.z, want.z));
      if (got.inten !== want.inten)
        report_mismatch($sformatf("intensity_out got %0d want %0d", got.inten, want.inten));
      if (got.rel !== want.rel)
        report_mismatch($sformatf("rel_time_ns got %0d want %0d", got.rel, want.rel));
    endtask

    task flush_missing();
      if (kept_q.size() != 0) begin
        report_mismatch($sformatf("%0d kept points never came out", kept_q.size()));
        kept_q.delete();
      end
    endtask

    function int pending();
      return kept_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;
  logic in_valid, in_ready, first_of_scan, point_finite;
  logic signed [COORD_WIDTH-1:0] x_mm, y_mm, z_mm, x_out, y_out, z_out;
  logic [INTEN_WIDTH-1:0] intensity_in, intensity_out;
  logic [TIME_WIDTH-1:0] point_time_ns, scan_start_ns;
  logic out_valid, out_ready;
  logic signed [REL_WIDTH-1:0] rel_time_ns;

  bit tx_idle, rx_idle;
  int rx_wait, rx_hold, points_sent, settings_used;
  range_gate_scoreboard sb;

  lidar_point_range_decimate_filter_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side: a long hold-off when requested, otherwise a short random
  // wait after each item while rx_idle is set.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    kept_point_t got;
    if (!rst && out_valid && out_ready) begin
      got.x = x_out;
      got.y = y_out;
      got.z = z_out;
      got.inten = intensity_out;
      got.rel = rel_time_ns;
      sb.check_point(got);
      rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
    end
  end

  task automatic send_point(input lidar_point_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    first_of_scan <= p.first;
    point_finite <= p.finite;
    x_mm <= p.x;
    y_mm <= p.y;
    z_mm <= p.z;
    intensity_in <= p.inten;
    point_time_ns <= p.pt;
    scan_start_ns <= p.st;
    do @(posedge clk); while (!in_ready);
    sb.note_point(p);
    points_sent++;
  endtask

  task automatic send_fields(input bit first, input bit finite, input int x, input int y,
                             input int z, input int inten, input logic [TIME_WIDTH-1:0] pt,
                             input logic [TIME_WIDTH-1:0] st);
    lidar_point_t p;
    p.first = first;
    p.finite = finite;
    p.x = COORD_WIDTH'(x);
    p.y = COORD_WIDTH'(y);
    p.z = COORD_WIDTH'(z);
    p.inten = INTEN_WIDTH'(inten);
    p.pt = pt;
    p.st = st;
    send_point(p);
  endtask

  // Stop offering points and wait until every kept point has come out, then
  // let the pipeline settle so dropped points are gone as well.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flush_missing();
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_WIDTH'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, CFG_DATA_WIDTH'(value));
  endtask

  task automatic apply_gate(input int factor, input int lo, input int hi);
    drain_results();
    write_reg(REG_DECIM, factor);
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    settings_used++;
  endtask

  function automatic void phase_setting(input int ph, output int factor, output int lo,
                                        output int hi);
    case (ph)
      0: begin factor = 1;   lo = 0;         hi = RANGE_MAX; end
      1: begin factor = 2;   lo = 1000;      hi = 3000;      end
      2: begin factor = 5;   lo = 0;         hi = 2500;      end
      3: begin factor = 255; lo = 0;         hi = RANGE_MAX; end
      4: begin factor = 0;   lo = 100;       hi = RANGE_MAX; end
      5: begin factor = 1;   lo = 2999;      hi = 3001;      end
      6: begin factor = 3;   lo = 2000;      hi = 1500;      end
      7: begin factor = 1;   lo = RANGE_MAX; hi = RANGE_MAX; end
      default: begin factor = 7; lo = 0; hi = 0; end
    endcase
  endfunction

  // Mix of full-width coordinates, points near the sensor and points sitting
  // on or next to one of the range bounds.
  function automatic lidar_point_t make_point(input bit first, input int lo_mm, input int hi_mm);
    lidar_point_t p;
    logic signed [COORD_WIDTH-1:0] c [3];
    int pick, axis, mag;
    longint off;
    p.first = first;
    p.finite = ($urandom_range(0, 11) != 0);
    p.inten = INTEN_WIDTH'($urandom);
    pick = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) c[i] = '0;
    if (pick < 2) begin
      for (int i = 0; i < 3; i++) c[i] = COORD_WIDTH'($urandom);
    end else if (pick < 6) begin
      for (int i = 0; i < 3; i++) c[i] = COORD_WIDTH'(int'($urandom_range(0, 8000)) - 4000);
    end else begin
      mag = (($urandom_range(0, 1) != 0) ? hi_mm : lo_mm) + int'($urandom_range(0, 2)) - 1;
      if (mag < 0) mag = 0;
      if (mag > COORD_MAX) mag = COORD_MAX;
      axis = $urandom_range(0, 2);
      c[axis] = ($urandom_range(0, 1) != 0) ? COORD_WIDTH'(-mag) : COORD_WIDTH'(mag);
    end
    p.x = c[0];
    p.y = c[1];
    p.z = c[2];
    if ($urandom_range(0, 3) == 0) begin
      p.pt = TIME_WIDTH'({$urandom, $urandom});
      p.st = TIME_WIDTH'({$urandom, $urandom});
    end else begin
      // Scan start well inside the range so the point time never wraps.
      p.st = {3'b001, 28'($urandom), $urandom};
      off = longint'($urandom) - 64'sd2147483648;
      if ($urandom_range(0, 4) == 0) off = off * 2;
      p.pt = TIME_WIDTH'(longint'(p.st) + off);
    end
    return p;
  endfunction

  initial begin
    int factor, lo, hi, scan_rate;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DECIM;
    cfg_data = '0;
    in_valid = 1'b0;
    first_of_scan = 1'b0;
    point_finite = 1'b0;
    x_mm = '0;
    y_mm = '0;
    z_mm = '0;
    intensity_in = '0;
    point_time_ns = '0;
    scan_start_ns = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gate: every point passes decimation, full range.
    send_fields(1, 1, 0, 0, 0, 0, '0, '0);
    send_fields(0, 1, COORD_MAX, 0, 0, 16'hFFFF, TIME_MAX, '0);
    send_fields(0, 1, COORD_MIN, 0, 0, 1, 63'd5, 63'd9);
    send_fields(0, 1, COORD_MAX, COORD_MAX, COORD_MAX, 2, '0, '0);
    send_fields(0, 1, COORD_MIN, COORD_MIN, COORD_MIN, 3, '0, '0);
    send_fields(0, 0, 10, 20, 30, 4, '0, '0);
    send_fields(0, 1, -5, 6, -7, 5, '0, TIME_MAX);
    send_fields(0, 1, 1, 1, 1, 6, 63'd2147484647, 63'd1000);
    send_fields(0, 1, 2, 2, 2, 7, 63'd2147484648, 63'd1000);
    send_fields(0, 1, 3, 3, 3, 8, '0, 63'd2147483648);
    send_fields(0, 1, 4, 4, 4, 9, '0, 63'd2147483649);
    send_fields(0, 1, 100, -200, 300, 10, 63'd5000000123, 63'd5000000000);

    // Factor three with upper data bits set, gate of 1000 to 2000 mm.
    drain_results();
    write_reg(REG_DECIM, 23'h7FFF03);
    write_reg(REG_MIN_RANGE, 1000);
    write_reg(REG_MAX_RANGE, 2000);
    settings_used++;
    send_fields(1, 1, 1000, 0, 0, 11, 63'd50, 63'd40);
    send_fields(0, 1, 0, 1000, 0, 12, 63'd50, 63'd40);
    send_fields(0, 1, 0, 0, 1000, 13, 63'd50, 63'd40);
    send_fields(0, 1, 0, 0, -1000, 14, 63'd50, 63'd40);
    send_fields(1, 1, 999, 0, 0, 15, 63'd50, 63'd40);
    send_fields(1, 1, 0, -2000, 0, 16, 63'd50, 63'd40);
    send_fields(1, 1, 0, 0, 2001, 17, 63'd50, 63'd40);
    send_fields(0, 1, 1500, 0, 0, 18, 63'd50, 63'd40);
    send_fields(1, 1, 1200, 500, 0, 19, 63'd50, 63'd40);

    // Zero factor with crossed bounds drops everything.
    apply_gate(0, 500, 400);
    send_fields(0, 1, 450, 0, 0, 20, 63'd7, 63'd3);
    send_fields(0, 1, 0, 0, 0, 21, 63'd7, 63'd3);

    // A write to the unused index must not touch any register.
    drain_results();
    write_reg(REG_UNUSED, RANGE_MAX);
    write_reg(REG_MIN_RANGE, 0);
    send_fields(0, 1, 450, 0, 0, 22, 63'd7, 63'd3);
    send_fields(0, 1, 300, 0, 0, 23, 63'd7, 63'd3);
    send_fields(0, 1, 0, -400, 0, 24, 63'd7, 63'd3);

    for (int ph = 0; ph < PHASES; ph++) begin
      phase_setting(ph, factor, lo, hi);
      apply_gate(factor, lo, hi);
      tx_idle = (ph % 3 != 0);
      rx_idle = (ph % 3 != 1);
      scan_rate = (factor > 16) ? 2 : 15;
      for (int i = 0; i < PHASE_POINTS; i++) begin
        // Back up the pipeline until the input stalls.
        if (ph == 0 && i == 10) rx_hold = HOLD_CYCLES;
        if (ph == 4 && i == PHASE_POINTS / 2) drain_results();
        send_point(make_point($urandom_range(0, scan_rate) == 0, lo, hi));
      end
    end
    drain_results();

    $display("Sent %0d points under %0d register settings; %0d kept points checked.",
             points_sent, settings_used, sb.checked);
    $display("Run included zero and 255 decimation, crossed and tight range gates,");
    $display("saturated relative times and a long output stall.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### lidar_point_range_decimate_filter_top.f
rtl/core/lprd_pkg.sv
rtl/core/lprd_cfg.sv
rtl/core/lprd_decim.sv
rtl/core/lprd_pipe.sv
rtl/core/lidar_point_range_decimate_filter_top.sv
sim/testbench.sv
